// ===== hdl/rvm_pkg.sv =====
// Package for the running vector mean block.
// Payload structs, sizes and state codes used by the top level.
// No dependencies.
package rvm_pkg;

   localparam int VECTOR_LENGTH = 1024;
   localparam int MEAN_WIDTH    = 32;
   localparam int COUNT_WIDTH   = 32;
   localparam int INDEX_WIDTH   = 10;
   localparam int ADDR_WIDTH    = $clog2(VECTOR_LENGTH);
   localparam int POS_WIDTH     = $clog2(VECTOR_LENGTH + 1);
   localparam int PROD_WIDTH    = 2 * COUNT_WIDTH;
   localparam int DIV_STEPS     = MEAN_WIDTH + 2;
   localparam int STEP_WIDTH    = $clog2(DIV_STEPS);
   localparam int WIDE_WIDTH    = DIV_STEPS + 2;

   localparam logic [POS_WIDTH-1:0] POS_LIMIT = POS_WIDTH'(VECTOR_LENGTH);

   localparam logic                   MODE_ADD   = 1'b0;
   localparam logic                   MODE_MERGE = 1'b1;

   typedef struct packed {
      logic                           mode;
      logic signed [MEAN_WIDTH-1:0]   sample_value;
      logic [COUNT_WIDTH-1:0]         partial_count;
      logic                           last_element;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]         element_index;
      logic signed [MEAN_WIDTH-1:0]   new_mean;
      logic [COUNT_WIDTH-1:0]         total_count;
      logic                           vector_done;
      logic                           count_saturated;
      logic                           length_error;
   } rsp_payload_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_READ = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_PREP = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

endpackage

// ===== hdl/running_vector_mean_top.sv =====
// Top level of the running vector mean block.
// Depends on rvm_pkg and rvm_ram.
//
// Keeps a per-element running mean (signed Q16.16) of vectors that arrive one
// element per request, plus the committed sample count. An element that
// updates the mean passes through RAM read, difference, one 32x32 multiply,
// divider setup, then a shared restoring divider that yields one quotient bit
// per cycle, 34 bits in all, and a write-back that also registers the result.
// An element with a zero count skips the multiply and the divider and goes
// from the RAM read to the result without a write. One element is in work at
// a time; a finished result waits in the output register while the next
// request is taken. The mean store needs no clearing pass after reset: a fill
// mark tells written entries from those that still read as zero.
module running_vector_mean_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  rvm_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rvm_pkg::rsp_payload_type rsp_data
);

   rvm_pkg::state_type state_ff, state_in;

   logic                                   mode_ff, mode_in;
   logic signed [rvm_pkg::MEAN_WIDTH-1:0]  x_ff, x_in;
   logic [rvm_pkg::COUNT_WIDTH-1:0]        pc_ff, pc_in;
   logic                                   last_ff, last_in;
   logic [rvm_pkg::POS_WIDTH-1:0]          pos_ff, pos_in;
   logic [rvm_pkg::POS_WIDTH-1:0]          fill_ff, fill_in;
   logic [rvm_pkg::COUNT_WIDTH-1:0]        sample_count_ff, sample_count_in;
   logic [rvm_pkg::COUNT_WIDTH-1:0]        pending_ff, pending_in;
   logic                                   ovf_ff, ovf_in;
   logic signed [rvm_pkg::MEAN_WIDTH-1:0]  m_ff, m_in;
   logic [rvm_pkg::COUNT_WIDTH-1:0]        mag_ff, mag_in;
   logic                                   neg_ff, neg_in;
   logic [rvm_pkg::PROD_WIDTH-1:0]         prod_ff, prod_in;
   logic                                   big_ff, big_in;
   logic [rvm_pkg::COUNT_WIDTH-1:0]        rem_ff, rem_in;
   logic [rvm_pkg::DIV_STEPS-1:0]          divq_ff, divq_in;
   logic [rvm_pkg::STEP_WIDTH-1:0]         step_ff, step_in;
   logic                                   upd_ff, upd_in;
   logic                                   err_ff, err_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   rvm_pkg::rsp_payload_type               rsp_data_ff, rsp_data_in;

   logic                                   rd_en;
   logic                                   wr_en;
   logic [rvm_pkg::MEAN_WIDTH-1:0]         rd_data;
   logic                                   done_fire;
   logic [rvm_pkg::COUNT_WIDTH:0]          count_sum;
   logic signed [rvm_pkg::MEAN_WIDTH-1:0]  m_sel;
   logic signed [rvm_pkg::MEAN_WIDTH:0]    diff;
   logic [rvm_pkg::MEAN_WIDTH:0]           diff_abs;
   logic [rvm_pkg::COUNT_WIDTH-1:0]        weight;
   logic [rvm_pkg::PROD_WIDTH-rvm_pkg::DIV_STEPS-1:0] prod_top;
   logic [rvm_pkg::COUNT_WIDTH:0]          trial;
   logic signed [rvm_pkg::WIDE_WIDTH-1:0]  mean_wide;
   logic signed [rvm_pkg::MEAN_WIDTH-1:0]  mean_sat;
   logic signed [rvm_pkg::MEAN_WIDTH-1:0]  mean_out;

   localparam logic signed [rvm_pkg::MEAN_WIDTH-1:0] MEAN_MAX =
      {1'b0, {(rvm_pkg::MEAN_WIDTH-1){1'b1}}};
   localparam logic signed [rvm_pkg::MEAN_WIDTH-1:0] MEAN_MIN =
      {1'b1, {(rvm_pkg::MEAN_WIDTH-1){1'b0}}};

   rvm_ram #(
      .WIDTH (rvm_pkg::MEAN_WIDTH),
      .DEPTH (rvm_pkg::VECTOR_LENGTH)
   ) u_mean_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff[rvm_pkg::ADDR_WIDTH-1:0]),
      .wr_data (mean_out),
      .rd_en   (rd_en),
      .rd_addr (pos_ff[rvm_pkg::ADDR_WIDTH-1:0]),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != rvm_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign done_fire = (state_ff == rvm_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // datapath terms
   always_comb begin
      count_sum = {1'b0, sample_count_ff} +
                  ((req_data.mode == rvm_pkg::MODE_MERGE) ?
                   {1'b0, req_data.partial_count} : (rvm_pkg::COUNT_WIDTH+1)'(1));
      m_sel    = (pos_ff < fill_ff) ? $signed(rd_data) : '0;
      diff     = {x_ff[rvm_pkg::MEAN_WIDTH-1], x_ff} - {m_sel[rvm_pkg::MEAN_WIDTH-1], m_sel};
      diff_abs = diff[rvm_pkg::MEAN_WIDTH] ? (-diff) : diff;
      weight   = (mode_ff == rvm_pkg::MODE_MERGE) ? pc_ff : rvm_pkg::COUNT_WIDTH'(1);
      prod_top = prod_ff[rvm_pkg::PROD_WIDTH-1:rvm_pkg::DIV_STEPS];
      trial    = {rem_ff, divq_ff[rvm_pkg::DIV_STEPS-1]};

      if (neg_ff) begin
         mean_wide = rvm_pkg::WIDE_WIDTH'(m_ff) - $signed({2'b00, divq_ff});
      end else begin
         mean_wide = rvm_pkg::WIDE_WIDTH'(m_ff) + $signed({2'b00, divq_ff});
      end

      if (big_ff) begin
         mean_sat = neg_ff ? MEAN_MIN : MEAN_MAX;
      end else if (mean_wide > rvm_pkg::WIDE_WIDTH'(MEAN_MAX)) begin
         mean_sat = MEAN_MAX;
      end else if (mean_wide < rvm_pkg::WIDE_WIDTH'(MEAN_MIN)) begin
         mean_sat = MEAN_MIN;
      end else begin
         mean_sat = mean_wide[rvm_pkg::MEAN_WIDTH-1:0];
      end

      mean_out = upd_ff ? mean_sat : m_ff;
   end

   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      x_in            = x_ff;
      pc_in           = pc_ff;
      last_in         = last_ff;
      pos_in          = pos_ff;
      fill_in         = fill_ff;
      sample_count_in = sample_count_ff;
      pending_in      = pending_ff;
      ovf_in          = ovf_ff;
      m_in            = m_ff;
      mag_in          = mag_ff;
      neg_in          = neg_ff;
      prod_in         = prod_ff;
      big_in          = big_ff;
      rem_in          = rem_ff;
      divq_in         = divq_ff;
      step_in         = step_ff;
      upd_in          = upd_ff;
      err_in          = err_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rd_en           = 1'b0;
      wr_en           = 1'b0;

      unique case (state_ff)
         rvm_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_data.mode;
               x_in    = req_data.sample_value;
               pc_in   = req_data.partial_count;
               last_in = req_data.last_element;
               upd_in  = 1'b0;
               if (pos_ff >= rvm_pkg::POS_LIMIT) begin
                  err_in   = 1'b1;
                  state_in = rvm_pkg::ST_DONE;
               end else begin
                  err_in   = 1'b0;
                  rd_en    = 1'b1;
                  state_in = rvm_pkg::ST_READ;
                  if (pos_ff == '0) begin
                     ovf_in     = count_sum[rvm_pkg::COUNT_WIDTH];
                     pending_in = count_sum[rvm_pkg::COUNT_WIDTH] ?
                                  '1 : count_sum[rvm_pkg::COUNT_WIDTH-1:0];
                  end
               end
            end
         end
         rvm_pkg::ST_READ: begin
            m_in     = m_sel;
            neg_in   = diff[rvm_pkg::MEAN_WIDTH];
            mag_in   = diff_abs[rvm_pkg::COUNT_WIDTH-1:0];
            upd_in   = (pending_ff != '0);
            state_in = (pending_ff != '0) ? rvm_pkg::ST_MUL : rvm_pkg::ST_DONE;
         end
         rvm_pkg::ST_MUL: begin
            prod_in  = mag_ff * weight;
            state_in = rvm_pkg::ST_PREP;
         end
         rvm_pkg::ST_PREP: begin
            big_in   = rvm_pkg::COUNT_WIDTH'(prod_top) >= pending_ff;
            rem_in   = rvm_pkg::COUNT_WIDTH'(prod_top);
            divq_in  = prod_ff[rvm_pkg::DIV_STEPS-1:0];
            step_in  = '0;
            state_in = rvm_pkg::ST_DIV;
         end
         rvm_pkg::ST_DIV: begin
            if (trial >= {1'b0, pending_ff}) begin
               rem_in  = rvm_pkg::COUNT_WIDTH'(trial - {1'b0, pending_ff});
               divq_in = {divq_ff[rvm_pkg::DIV_STEPS-2:0], 1'b1};
            end else begin
               rem_in  = trial[rvm_pkg::COUNT_WIDTH-1:0];
               divq_in = {divq_ff[rvm_pkg::DIV_STEPS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == rvm_pkg::STEP_WIDTH'(rvm_pkg::DIV_STEPS - 1)) begin
               state_in = rvm_pkg::ST_DONE;
            end
         end
         rvm_pkg::ST_DONE: begin
            if (done_fire) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.element_index   = pos_ff[rvm_pkg::INDEX_WIDTH-1:0];
               rsp_data_in.total_count     = pending_ff;
               rsp_data_in.length_error    = err_ff;
               rsp_data_in.new_mean        = err_ff ? '0 : mean_out;
               rsp_data_in.vector_done     = !err_ff && last_ff;
               rsp_data_in.count_saturated = !err_ff && ovf_ff;
               wr_en = upd_ff;
               if (upd_ff && (pos_ff == fill_ff)) begin
                  fill_in = fill_ff + 1'b1;
               end
               if (last_ff) begin
                  pos_in = '0;
                  if (!err_ff) begin
                     sample_count_in = pending_ff;
                  end
               end else if (!err_ff) begin
                  pos_in = pos_ff + 1'b1;
               end
               state_in = rvm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rvm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= rvm_pkg::ST_IDLE;
         pos_ff          <= '0;
         fill_ff         <= '0;
         sample_count_ff <= '0;
         pending_ff      <= '0;
         ovf_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pos_ff          <= pos_in;
         fill_ff         <= fill_in;
         sample_count_ff <= sample_count_in;
         pending_ff      <= pending_in;
         ovf_ff          <= ovf_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      x_ff        <= x_in;
      pc_ff       <= pc_in;
      last_ff     <= last_in;
      m_ff        <= m_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      big_ff      <= big_in;
      rem_ff      <= rem_in;
      divq_ff     <= divq_in;
      step_ff     <= step_in;
      upd_ff      <= upd_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hdl/rvm_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
